// ----- sv/i2t_pkg.sv -----
// Shared types, constants and the digit-to-ASCII map for the integer to
// hexadecimal and base-11 text block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2t_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int DIGIT_W        = 4;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [6:0]         ascii_t;

  localparam ascii_t ASCII_ZERO = 7'h30;
  localparam ascii_t ASCII_A    = 7'h41;
  localparam digit_t RADIX_ELEVEN = 4'd11;
  localparam digit_t DIGIT_TEN    = 4'd10;

  // control word for one base-11 digit cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic dbl;
  } cell_ctl_t;

  function automatic ascii_t digit_char(input digit_t d);
    ascii_t c;
    if (d < DIGIT_TEN) begin
      c = ASCII_ZERO + {3'b000, d};
    end else begin
      c = ASCII_A + {3'b000, d - DIGIT_TEN};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/i2t_channels.sv -----
// Valid/ready channel interfaces for the input word and the result word.
// Depends on i2t_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface i2t_in_if #(
  parameter int VALUE_BITS = i2t_pkg::VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2t_out_if ();
  logic                valid;
  logic                ready;
  i2t_pkg::ascii_t     ascii_char;
  logic                radix_is_eleven;
  logic                end_of_number;
  logic                last;

  modport source (output valid, output ascii_char, output radix_is_eleven,
                  output end_of_number, output last, input ready);
  modport sink   (input valid, input ascii_char, input radix_is_eleven,
                  input end_of_number, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/i2t_b11_cell.sv -----
// One base-11 digit cell: clears, or doubles its digit and adds the carry
// from below, or takes the lower neighbour's digit when the row shifts out.
// Depends on i2t_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2t_b11_cell (
  input  wire logic               clk,
  input  wire i2t_pkg::cell_ctl_t ctl,
  input  wire logic               carry_in,
  input  wire i2t_pkg::digit_t    lower_digit,
  output      i2t_pkg::digit_t    digit,
  output      logic               carry_out
);

  i2t_pkg::digit_t digit_r;
  i2t_pkg::digit_t digit_nxt;
  logic [4:0]      dbl_sum;
  logic [4:0]      dbl_red;

  assign dbl_sum   = {digit_r, carry_in};
  assign carry_out = (dbl_sum >= {1'b0, i2t_pkg::RADIX_ELEVEN});
  assign dbl_red   = dbl_sum - {1'b0, i2t_pkg::RADIX_ELEVEN};
  assign digit     = digit_r;

  always_comb begin
    priority if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.shift) begin
      digit_nxt = lower_digit;
    end else if (ctl.dbl) begin
      digit_nxt = carry_out ? dbl_red[3:0] : dbl_sum[3:0];
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/integer_to_hex_and_base11_text_core.sv -----
// Top level: integer to hexadecimal then base-11 ASCII text, one char a word.
// Depends on i2t_pkg, i2t_channels (i2t_in_if, i2t_out_if) and i2t_b11_cell.
//
//   channel | dir | payload                                           | per item
//   in_ch   | in  | value [VALUE_BITS-1:0]                            | 1 word
//   out_ch  | out | ascii_char[6:0], radix_is_eleven, end_of_number,  | 2..17 words
//           |     | last                                              |
//
// The idle state takes the word, the value is shifted MSB first through the
// row of base-11 cells at one bit a cycle, then each digit slot, hex first,
// is emitted or skipped as a leading zero.
// in_ch.ready is high only between items. Output stalls hold the emit steps.
// Reset is synchronous and clears the sequencer and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_hex_and_base11_text_core #(
  parameter int VALUE_BITS = i2t_pkg::VALUE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  i2t_in_if.sink     in_ch,
  i2t_out_if.source  out_ch
);

  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int HEX_W      = HEX_DIGITS * 4;
  // ceil(VALUE_BITS * log11(2)); no power of 11 is a power of 2
  localparam int B11_DIGITS = (VALUE_BITS * 2890649 + 9999999) / 10000000;
  localparam int MAX_DIGITS = (HEX_DIGITS > B11_DIGITS) ? HEX_DIGITS : B11_DIGITS;
  localparam int BCW        = $clog2(VALUE_BITS);
  localparam int DCW        = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_HEX  = 2'd2;
  localparam logic [1:0] S_B11  = 2'd3;

  logic [1:0]       state_r,   state_nxt;
  logic [HEX_W-1:0] hex_r,     hex_nxt;
  logic [BCW-1:0]   bcnt_r,    bcnt_nxt;
  logic [DCW-1:0]   dcnt_r,    dcnt_nxt;
  logic             started_r, started_nxt;

  logic             out_valid_r, out_valid_nxt;
  i2t_pkg::ascii_t  out_char_r,  out_char_nxt;
  logic             out_r11_r,   out_r11_nxt;
  logic             out_eon_r,   out_eon_nxt;
  logic             out_last_r,  out_last_nxt;

  i2t_pkg::cell_ctl_t ctl;
  logic               bit_in;
  logic               slot_free;
  logic [3:0]         hex_nib;
  i2t_pkg::digit_t    b11_top;

  i2t_pkg::digit_t    digits [B11_DIGITS];
  logic               carry  [B11_DIGITS+1];

  assign carry[0] = bit_in;

  for (genvar i = 0; i < B11_DIGITS; i++) begin : g_cell
    i2t_pkg::digit_t lower;
    if (i == 0) begin : g_low
      assign lower = '0;
    end else begin : g_mid
      assign lower = digits[i-1];
    end
    i2t_b11_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .carry_in    (carry[i]),
      .lower_digit (lower),
      .digit       (digits[i]),
      .carry_out   (carry[i+1])
    );
  end

  assign hex_nib   = hex_r[HEX_W-1 -: 4];
  assign b11_top   = digits[B11_DIGITS-1];
  assign slot_free = !out_valid_r || out_ch.ready;
  assign bit_in    = hex_r[VALUE_BITS-1];

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.ascii_char      = out_char_r;
  assign out_ch.radix_is_eleven = out_r11_r;
  assign out_ch.end_of_number   = out_eon_r;
  assign out_ch.last            = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    hex_nxt       = hex_r;
    bcnt_nxt      = bcnt_r;
    dcnt_nxt      = dcnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_r11_nxt   = out_r11_r;
    out_eon_nxt   = out_eon_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          hex_nxt   = HEX_W'(in_ch.value);
          bcnt_nxt  = '0;
          ctl.clear = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        // rotate so the value is back in place after VALUE_BITS steps
        ctl.dbl  = 1'b1;
        hex_nxt[VALUE_BITS-1:0] = {hex_r[VALUE_BITS-2:0], hex_r[VALUE_BITS-1]};
        bcnt_nxt = bcnt_r + BCW'(1);
        if (bcnt_r == BCW'(VALUE_BITS - 1)) begin
          dcnt_nxt    = DCW'(HEX_DIGITS);
          started_nxt = 1'b0;
          state_nxt   = S_HEX;
        end
      end
      S_HEX: begin
        if (!started_r && hex_nib == 4'd0 && dcnt_r != DCW'(1)) begin
          hex_nxt  = hex_r << 4;
          dcnt_nxt = dcnt_r - DCW'(1);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = i2t_pkg::digit_char(hex_nib);
          out_r11_nxt   = 1'b0;
          out_eon_nxt   = (dcnt_r == DCW'(1));
          out_last_nxt  = 1'b0;
          hex_nxt       = hex_r << 4;
          dcnt_nxt      = dcnt_r - DCW'(1);
          started_nxt   = 1'b1;
          if (dcnt_r == DCW'(1)) begin
            dcnt_nxt    = DCW'(B11_DIGITS);
            started_nxt = 1'b0;
            state_nxt   = S_B11;
          end
        end
      end
      S_B11: begin
        if (!started_r && b11_top == '0 && dcnt_r != DCW'(1)) begin
          ctl.shift = 1'b1;
          dcnt_nxt  = dcnt_r - DCW'(1);
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = i2t_pkg::digit_char(b11_top);
          out_r11_nxt   = 1'b1;
          out_eon_nxt   = (dcnt_r == DCW'(1));
          out_last_nxt  = (dcnt_r == DCW'(1));
          ctl.shift     = 1'b1;
          dcnt_nxt      = dcnt_r - DCW'(1);
          started_nxt   = 1'b1;
          if (dcnt_r == DCW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hex_r      <= hex_nxt;
    bcnt_r     <= bcnt_nxt;
    dcnt_r     <= dcnt_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_r11_r  <= out_r11_nxt;
    out_eon_r  <= out_eon_nxt;
    out_last_r <= out_last_nxt;
  end

  // the cell row is wide enough: nothing carries out of the top digit
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CONV |-> !carry[B11_DIGITS])
    else $error("base-11 row overflow");

  a_last_closes_b11: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_eon_r && out_r11_r)
    else $error("last word not at end of base-11 string");

  a_b11_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r11_r |-> out_char_r <= i2t_pkg::ASCII_A)
    else $error("base-11 digit out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == S_CONV && bcnt_r == '0)
    else $error("accepted word did not start conversion");

endmodule

`default_nettype wire

// ----- tb/tb_integer_to_hex_and_base11_text_core.sv -----
// Self-checking bench for the integer to hex and base-11 text core: a table of directed
// values, then random values, with every output word checked against its row's typed text or a local predictor.
// Depends on i2t_pkg, i2t_channels and integer_to_hex_and_base11_text_core.
`timescale 1ns / 1ps

module tb_integer_to_hex_and_base11_text_core;

  localparam int VALUE_BITS   = i2t_pkg::VALUE_BITS_DEF;
  localparam int RANDOM_ITEMS = 358;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 100;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    i2t_pkg::ascii_t ch;
    logic            r11;
    logic            eon;
    logic            last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n;

  i2t_in_if  #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  i2t_out_if                            out_ch ();

  integer_to_hex_and_base11_text_core #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  text_char_t char_q[$];
  text_char_t seen_char;
  int         errors = 0;
  int         cycles = 0;

  // directed table; an empty string means the row is left to the predictor
  value_t row_value[$];
  string  row_hex[$];
  string  row_b11[$];

  // idle shaping
  int   calm_left  = 0;
  logic in_calm    = 1'b0;
  logic out_calm   = 1'b0;
  int   stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // digits of one radix, most significant first, no leading zeros
  task automatic push_radix(input longint unsigned v, input int unsigned radix,
                            input logic r11);
    i2t_pkg::digit_t digs[$];
    longint unsigned n;
    text_char_t      c;
    n = v;
    do begin
      digs.push_front(i2t_pkg::digit_t'(n % radix));
      n = n / radix;
    end while (n != 0);
    for (int i = 0; i < digs.size(); i++) begin
      if (digs[i] < i2t_pkg::DIGIT_TEN) begin
        c.ch = i2t_pkg::ASCII_ZERO + i2t_pkg::ascii_t'(digs[i]);
      end else begin
        c.ch = i2t_pkg::ASCII_A + i2t_pkg::ascii_t'(digs[i] - i2t_pkg::DIGIT_TEN);
      end
      c.r11  = r11;
      c.eon  = (i == digs.size() - 1);
      c.last = c.eon && r11;
      char_q = {char_q, c};
    end
  endtask

  task automatic push_typed(input string txt, input logic r11);
    text_char_t c;
    for (int i = 0; i < txt.len(); i++) begin
      c.ch   = i2t_pkg::ascii_t'(txt[i]);
      c.r11  = r11;
      c.eon  = (i == txt.len() - 1);
      c.last = c.eon && r11;
      char_q = {char_q, c};
    end
  endtask

  task automatic add_row(input value_t v, input string hex_txt, input string b11_txt);
    row_value = {row_value, v};
    row_hex   = {row_hex, hex_txt};
    row_b11   = {row_b11, b11_txt};
  endtask

  // offer one word after a random gap; valid stays high when there is no gap
  task automatic offer_value(input value_t v, input string hex_txt, input string b11_txt);
    int gap;
    gap = in_calm ? 0 : (($urandom_range(0, 99) < 50) ? 0 : pick_gap());
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    if (hex_txt.len() == 0) begin
      push_radix(longint'(v), 16, 1'b0);
      push_radix(longint'(v), 11, 1'b1);
    end else begin
      push_typed(hex_txt, 1'b0);
      push_typed(b11_txt, 1'b1);
    end
  endtask

  function automatic value_t random_value();
    longint unsigned p;
    int              k;
    case ($urandom_range(0, 5))
      0: return value_t'($urandom);
      1: return value_t'($urandom_range(0, 300));
      2: return value_t'($urandom >> $urandom_range(0, 31));
      3: begin
        p = longint'(1) << (4 * $urandom_range(0, 7));
        return value_t'(p + $urandom_range(0, 2) - 1);
      end
      4: begin
        p = 1;
        k = $urandom_range(0, 8);
        repeat (k) p = p * 11;
        return value_t'(p + $urandom_range(0, 2) - 1);
      end
      default: begin
        k = $urandom_range(1, VALUE_BITS);
        return value_t'((longint'(1) << k) - 1);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm_left <= $urandom_range(40, 400);
      in_calm   <= ($urandom_range(0, 3) == 0);
      out_calm  <= ($urandom_range(0, 3) == 0);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!out_calm && $urandom_range(0, 99) < 25) begin
      stall_left   <= pick_gap() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result word check
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (char_q.size() == 0) begin
        $error("unexpected word: ascii_char %h", out_ch.ascii_char);
        errors++;
      end else begin
        seen_char = char_q.pop_front();
        if (out_ch.ascii_char !== seen_char.ch) begin
          $error("ascii_char: expected %h, got %h", seen_char.ch, out_ch.ascii_char);
          errors++;
        end
        if (out_ch.radix_is_eleven !== seen_char.r11) begin
          $error("radix_is_eleven: expected %b, got %b", seen_char.r11,
                 out_ch.radix_is_eleven);
          errors++;
        end
        if (out_ch.end_of_number !== seen_char.eon) begin
          $error("end_of_number: expected %b, got %b", seen_char.eon, out_ch.end_of_number);
          errors++;
        end
        if (out_ch.last !== seen_char.last) begin
          $error("last: expected %b, got %b", seen_char.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;

    add_row(value_t'(0),          "0",        "0");
    add_row(value_t'(1),          "1",        "1");
    add_row(value_t'(10),         "A",        "A");
    add_row(value_t'(11),         "B",        "10");
    add_row(value_t'(15),         "F",        "14");
    add_row(value_t'(16),         "10",       "15");
    add_row(value_t'(31'h7FFFFFFF), "7FFFFFFF", "A02220281");
    add_row(value_t'(31'h7FFFFFFE), "", "");
    add_row(value_t'(31'h40000000), "", "");
    add_row(value_t'(31'h55555555), "", "");
    add_row(value_t'(31'h2AAAAAAA), "", "");
    add_row(value_t'(31'h10000000), "", "");
    add_row(value_t'(31'h0FFFFFFF), "", "");
    add_row(value_t'(121),          "", "");
    add_row(value_t'(1330),         "", "");
    add_row(value_t'(1331),         "", "");
    add_row(value_t'(255),          "", "");
    add_row(value_t'(256),          "", "");
    add_row(value_t'(4095),         "", "");
    add_row(value_t'(19487170),     "", "");
    add_row(value_t'(214358880),    "", "");
    add_row(value_t'(214358881),    "", "");

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < row_value.size(); i++) begin
      offer_value(row_value[i], row_hex[i], row_b11[i]);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      offer_value(random_value(), "", "");
    end
    in_ch.valid <= 1'b0;

    while (char_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
